// File: hw/rtl/tcp_probe_header_builder_defines.svh
// ---------------------------------------------------------------------------
// tcp_probe_header_builder_defines
// Assertion macros shared by the checker of the probe header builder.
// ---------------------------------------------------------------------------
`ifndef TCP_PROBE_HEADER_BUILDER_DEFINES_SVH
`define TCP_PROBE_HEADER_BUILDER_DEFINES_SVH

// same-cycle implication
`define TPHB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tphb assertion failed");

// next-cycle implication
`define TPHB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tphb assertion failed");

`endif

// File: hw/rtl/tphb_pkg.sv
// ---------------------------------------------------------------------------
// tphb_pkg
// Types, constants and checksum helper of the probe header builder.
// ---------------------------------------------------------------------------
package tphb_pkg;

    localparam int NumWords = 10;
    localparam int IdxW     = 4;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 32;

    localparam logic [IdxW-1:0] LastIdx = IdxW'(NumWords - 1);

    localparam logic [CfgIdxW-1:0] CfgSrcAddr = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgSrcPort = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgTtl     = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgIdent   = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgWindow  = 3'd4;

    localparam logic [15:0] RstSrcPort = 16'd12345;
    localparam logic [7:0]  RstTtl     = 8'd255;
    localparam logic [15:0] RstIdent   = 16'd54321;
    localparam logic [15:0] RstWindow  = 16'd32767;

    localparam logic [7:0]  ProtoTcp   = 8'd6;
    localparam logic [15:0] TotalLen   = 16'd40;
    localparam logic [15:0] TcpHdrLen  = 16'd20;
    localparam logic [15:0] VerIhlTos  = 16'h4500;
    localparam logic [7:0]  OffsetByte = 8'h50;
    localparam logic [7:0]  FlagSyn    = 8'h02;
    localparam logic [7:0]  FlagAck    = 8'h10;

    typedef logic [31:0] word_t;
    typedef word_t [NumWords-1:0] hdr_t;

    typedef struct packed {
        logic [31:0] source_address;
        logic [15:0] source_port;
        logic [7:0]  time_to_live;
        logic [15:0] ident_value;
        logic [15:0] window_size;
    } cfg_t;

    typedef struct packed {
        logic load;
    } ser_ctrl_t;

    typedef struct packed {
        logic free;
    } ser_stat_t;

    function automatic logic [15:0] fold_invert(input logic [19:0] acc);
        logic [16:0] s1;
        logic [16:0] s2;
        s1 = {13'd0, acc[19:16]} + {1'b0, acc[15:0]};
        s2 = {16'd0, s1[16]} + {1'b0, s1[15:0]};
        return ~s2[15:0];
    endfunction

endpackage

// File: hw/rtl/tphb_probe_if.sv
// ---------------------------------------------------------------------------
// tphb_probe_if
// Probe request channel: target address, target port and probe kind.
// ---------------------------------------------------------------------------
interface tphb_probe_if;
    logic        valid;
    logic        ready;
    logic [31:0] target_address;
    logic [15:0] target_port;
    logic        req_type;

    modport source (output valid, output target_address, output target_port,
                    output req_type, input ready);
    modport sink   (input valid, input target_address, input target_port,
                    input req_type, output ready);
endinterface

// File: hw/rtl/tphb_header_if.sv
// ---------------------------------------------------------------------------
// tphb_header_if
// Header word channel: one 32-bit header word per beat.
// ---------------------------------------------------------------------------
interface tphb_header_if;
    logic        valid;
    logic        ready;
    logic [31:0] header_word;
    logic [3:0]  word_index;
    logic        last_word;

    modport source (output valid, output header_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input header_word, input word_index,
                    input last_word, output ready);
endinterface

// File: hw/rtl/tphb_hdr_calc.sv
// ---------------------------------------------------------------------------
// tphb_hdr_calc
// Builds the ten header words with IPv4 and TCP checksums.
// ---------------------------------------------------------------------------
module tphb_hdr_calc
(
    input  tphb_pkg::cfg_t cfg,
    input  logic [31:0]    target_address,
    input  logic [15:0]    target_port,
    input  logic           req_type,
    output tphb_pkg::hdr_t hdr
);
    import tphb_pkg::*;

    logic [7:0]  flags;
    logic [19:0] ip_sum;
    logic [19:0] tcp_sum;
    logic [15:0] ip_csum;
    logic [15:0] tcp_csum;
    logic [15:0] ttl_proto;
    logic [15:0] off_flags;

    assign flags     = req_type ? FlagAck : FlagSyn;
    assign ttl_proto = {cfg.time_to_live, ProtoTcp};
    assign off_flags = {OffsetByte, flags};

    assign ip_sum = {4'd0, VerIhlTos} + {4'd0, TotalLen} + {4'd0, cfg.ident_value}
                  + {4'd0, ttl_proto}
                  + {4'd0, cfg.source_address[31:16]} + {4'd0, cfg.source_address[15:0]}
                  + {4'd0, target_address[31:16]} + {4'd0, target_address[15:0]};

    assign tcp_sum = {4'd0, cfg.source_address[31:16]} + {4'd0, cfg.source_address[15:0]}
                   + {4'd0, target_address[31:16]} + {4'd0, target_address[15:0]}
                   + {12'd0, ProtoTcp} + {4'd0, TcpHdrLen}
                   + {4'd0, cfg.source_port} + {4'd0, target_port}
                   + {4'd0, off_flags} + {4'd0, cfg.window_size};

    assign ip_csum  = fold_invert(ip_sum);
    assign tcp_csum = fold_invert(tcp_sum);

    assign hdr[0] = {VerIhlTos, TotalLen};
    assign hdr[1] = {cfg.ident_value, 16'd0};
    assign hdr[2] = {ttl_proto, ip_csum};
    assign hdr[3] = cfg.source_address;
    assign hdr[4] = target_address;
    assign hdr[5] = {cfg.source_port, target_port};
    assign hdr[6] = 32'd0;
    assign hdr[7] = 32'd0;
    assign hdr[8] = {off_flags, cfg.window_size};
    assign hdr[9] = {tcp_csum, 16'd0};

endmodule

// File: hw/rtl/tphb_serializer.sv
// ---------------------------------------------------------------------------
// tphb_serializer
// Holds one built header and shifts it out one word per beat.
// ---------------------------------------------------------------------------
module tphb_serializer
(
    input  logic              clk,
    input  logic              rst_n,
    input  tphb_pkg::ser_ctrl_t ctrl,
    input  tphb_pkg::hdr_t    hdr,
    output tphb_pkg::ser_stat_t stat,
    tphb_header_if.source     header
);
    import tphb_pkg::*;

    hdr_t            words_reg;
    logic [IdxW-1:0] idx_reg;
    logic            valid_reg;
    logic            beat;
    logic            last;

    assign last      = (idx_reg == LastIdx);
    assign beat      = valid_reg && header.ready;
    assign stat.free = !valid_reg || (beat && last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (ctrl.load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (beat)
        begin
            if (last)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // load a new header, or advance the shift line on each beat but the last
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            words_reg <= hdr;
        end
        else if (beat && !last)
        begin
            for (int i = 0; i < NumWords - 1; i++)
            begin
                words_reg[i] <= words_reg[i+1];
            end
        end
    end

    assign header.valid       = valid_reg;
    assign header.header_word = words_reg[0];
    assign header.word_index  = idx_reg;
    assign header.last_word   = last;

endmodule

// File: hw/rtl/tcp_probe_header_builder.sv
// ---------------------------------------------------------------------------
// tcp_probe_header_builder: IPv4 + TCP probe header generator
// Path: a probe is taken into the input register, then loaded into the serializer once it is free.
// Headers go out one word per beat; the next header loads on the last beat of the one before.
// A second probe is held in the input register while a header drains.
// Reset: asynchronous, active low; clears valids, loads register defaults.
// ---------------------------------------------------------------------------
module tcp_probe_header_builder
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [tphb_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [tphb_pkg::CfgDataW-1:0] cfg_wdata,
    tphb_probe_if.sink                   probe,
    tphb_header_if.source                header
);
    import tphb_pkg::*;

    cfg_t        cfg_reg;
    logic        in_valid_reg;
    logic [31:0] addr_reg;
    logic [15:0] port_reg;
    logic        kind_reg;
    hdr_t        hdr;
    ser_ctrl_t   ctrl;
    ser_stat_t   stat;

    assign ctrl.load   = in_valid_reg && stat.free;
    assign probe.ready = !in_valid_reg || ctrl.load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_address <= '0;
            cfg_reg.source_port    <= RstSrcPort;
            cfg_reg.time_to_live   <= RstTtl;
            cfg_reg.ident_value    <= RstIdent;
            cfg_reg.window_size    <= RstWindow;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CfgSrcAddr: cfg_reg.source_address <= cfg_wdata;
                CfgSrcPort: cfg_reg.source_port    <= cfg_wdata[15:0];
                CfgTtl:     cfg_reg.time_to_live   <= cfg_wdata[7:0];
                CfgIdent:   cfg_reg.ident_value    <= cfg_wdata[15:0];
                CfgWindow:  cfg_reg.window_size    <= cfg_wdata[15:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (probe.ready)
        begin
            in_valid_reg <= probe.valid;
        end
    end

    // hold the probe until the serializer takes it
    always_ff @(posedge clk)
    begin
        if (probe.valid && probe.ready)
        begin
            addr_reg <= probe.target_address;
            port_reg <= probe.target_port;
            kind_reg <= probe.req_type;
        end
    end

    tphb_hdr_calc u_calc
    (
        .cfg            (cfg_reg),
        .target_address (addr_reg),
        .target_port    (port_reg),
        .req_type       (kind_reg),
        .hdr            (hdr)
    );

    tphb_serializer u_ser
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .hdr    (hdr),
        .stat   (stat),
        .header (header)
    );

endmodule

// File: hw/rtl/tphb_checker.sv
// ---------------------------------------------------------------------------
// tphb_checker
// Port-level checks on the header channel of the probe header builder.
// ---------------------------------------------------------------------------
`include "tcp_probe_header_builder_defines.svh"

module tphb_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] header_word,
    input logic [3:0]  word_index,
    input logic        last_word
);
    import tphb_pkg::*;

    `TPHB_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(header_word) && $stable(word_index))
    `TPHB_ASSERT_NOW(a_last_mark, clk, rst_n, out_valid, last_word == (word_index == LastIdx))
    `TPHB_ASSERT_NOW(a_index_range, clk, rst_n, out_valid, word_index <= LastIdx)
    `TPHB_ASSERT_NEXT(a_word_order, clk, rst_n, out_valid && out_ready && !last_word,
        out_valid && (word_index == $past(word_index) + 4'd1))

endmodule

bind tcp_probe_header_builder tphb_checker u_tphb_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (header.valid),
    .out_ready   (header.ready),
    .header_word (header.header_word),
    .word_index  (header.word_index),
    .last_word   (header.last_word)
);
